[sv/rfce_pkg.sv]
`timescale 1ns / 1ps

package rfce_pkg;

   // Default sizes of the fern table and the pixel store.
   localparam int DEF_NUM_FERNS     = 512;
   localparam int DEF_NUM_DECISIONS = 4;
   localparam int DEF_MAX_PIXELS    = 8192;

   // Field widths fixed by the interface.
   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 13;
   localparam int LOC_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int FERN_W   = 9;
   localparam int CODE_W   = 8;
   localparam int IMGW_W   = 9;
   localparam int PADDR_W  = 17;

   localparam logic [IMGW_W-1:0] IMGW_RESET = 9'd80;

   // Depth of the command queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // Function selector codes on req_func.
   localparam logic [FUNC_W-1:0] FUNC_WR_TESTER = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WR_PIXEL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE   = 2'd2;

   // Classified operation carried through the queue.
   typedef enum logic [1:0] {
      OP_WR_TESTER,
      OP_WR_PIXEL,
      OP_COMPUTE
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   index;
      logic [LOC_W-1:0]     loc_x;
      logic [LOC_W-1:0]     loc_y;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

   // Result transaction handed from the back end to the top level.
   typedef struct packed {
      logic                 strobe;
      logic [FERN_W-1:0]    fern_number;
      logic [CODE_W-1:0]    code;
      logic                 addr_error;
   } rsp_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

endpackage

[sv/random_fern_code_encoder.sv]
`timescale 1ns / 1ps
// Random-fern binary code encoder.
// Command channel: a transaction is taken at a clock edge where start is high
// and busy is low. req_func selects a tester write, a pixel write or a code
// computation for the fern named by req_index. Writes and computations whose
// index is out of range, and the unused selector, are dropped.
// Result channel: for each computation, rsp_strobe is high for one cycle with
// rsp_fern_number, rsp_code and rsp_addr_error; the receiver must take it then.
// Configuration: csr_image_width is written when csr_valid and csr_ready are
// high; csr_ready is always high. Write it only while the block is idle.
// Flow: a front stage and a two-entry queue take commands while the back end
// works. A write is done as its entry leaves the queue. A computation holds the
// back end, which pops no further command, while it issues one tester read per
// cycle and then while the tester-RAM read, address multiply and pixel-RAM read
// pipeline drains. busy rises only when the hold stage and the queue are full.
// Reset clears the queue, the sequencer and the result strobe and sets the
// image width to 80; tester and pixel memories keep their contents.

module random_fern_code_encoder #(
   parameter int NUM_FERNS     = rfce_pkg::DEF_NUM_FERNS,
   parameter int NUM_DECISIONS = rfce_pkg::DEF_NUM_DECISIONS,
   parameter int MAX_PIXELS    = rfce_pkg::DEF_MAX_PIXELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rfce_pkg::FUNC_W-1:0]   req_func,
   input  logic [rfce_pkg::INDEX_W-1:0]  req_index,
   input  logic [rfce_pkg::LOC_W-1:0]    req_loc_x,
   input  logic [rfce_pkg::LOC_W-1:0]    req_loc_y,
   input  logic signed [rfce_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [rfce_pkg::FERN_W-1:0]   rsp_fern_number,
   output logic [rfce_pkg::CODE_W-1:0]   rsp_code,
   output logic                          rsp_addr_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rfce_pkg::IMGW_W-1:0]   csr_image_width
);

   import rfce_pkg::*;

   logic [IMGW_W-1:0] image_width_ff, image_width_in;
   logic              q_push, q_pop, q_full, q_empty;
   cmd_type           q_data, q_head;
   rsp_type           rsp;

   // Image width register.
   assign csr_ready      = 1'b1;
   assign image_width_in = (csr_valid && csr_ready) ? csr_image_width : image_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMGW_RESET;
      end else begin
         image_width_ff <= image_width_in;
      end
   end

   rfce_front #(
      .NUM_FERNS     (NUM_FERNS),
      .NUM_DECISIONS (NUM_DECISIONS),
      .MAX_PIXELS    (MAX_PIXELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_func),
      .req_index (req_index),
      .req_loc_x (req_loc_x),
      .req_loc_y (req_loc_y),
      .req_value (req_value),
      .q_push    (q_push),
      .q_data    (q_data),
      .q_full    (q_full)
   );

   rfce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   rfce_back #(
      .NUM_FERNS     (NUM_FERNS),
      .NUM_DECISIONS (NUM_DECISIONS),
      .MAX_PIXELS    (MAX_PIXELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .image_width (image_width_ff),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp         (rsp)
   );

   // Result transaction ports.
   assign rsp_strobe      = rsp.strobe;
   assign rsp_fern_number = rsp.fern_number;
   assign rsp_code        = rsp.code;
   assign rsp_addr_error  = rsp.addr_error;

endmodule

[sv/rfce_ram.sv]
`timescale 1ns / 1ps

module rfce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rfce_queue.sv]
`timescale 1ns / 1ps

module rfce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rfce_pkg::cmd_type push_data,
   input  logic             pop,
   output rfce_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);

   import rfce_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/rfce_front.sv]
`timescale 1ns / 1ps

module rfce_front #(
   parameter int NUM_FERNS     = rfce_pkg::DEF_NUM_FERNS,
   parameter int NUM_DECISIONS = rfce_pkg::DEF_NUM_DECISIONS,
   parameter int MAX_PIXELS    = rfce_pkg::DEF_MAX_PIXELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rfce_pkg::FUNC_W-1:0]   req_func,
   input  logic [rfce_pkg::INDEX_W-1:0]  req_index,
   input  logic [rfce_pkg::LOC_W-1:0]    req_loc_x,
   input  logic [rfce_pkg::LOC_W-1:0]    req_loc_y,
   input  logic [rfce_pkg::VALUE_W-1:0]  req_value,
   output logic                          q_push,
   output rfce_pkg::cmd_type             q_data,
   input  logic                          q_full
);

   import rfce_pkg::*;

   localparam int TESTER_DEPTH = NUM_FERNS * NUM_DECISIONS;

   logic     accept;
   logic     keep;
   op_type   op;
   logic     held_ff, held_in;
   cmd_type  cmd_ff;

   // A held command that cannot enter the queue blocks the next transaction.
   assign busy   = held_ff && q_full;
   assign accept = start && !busy;
   assign q_push = held_ff;
   assign q_data = cmd_ff;

   // Classify the transaction and drop those that do nothing.
   always_comb begin
      op   = OP_WR_TESTER;
      keep = 1'b0;
      unique case (req_func)
         FUNC_WR_TESTER: begin
            op   = OP_WR_TESTER;
            keep = (32'(req_index) < TESTER_DEPTH);
         end
         FUNC_WR_PIXEL: begin
            op   = OP_WR_PIXEL;
            keep = (32'(req_index) < MAX_PIXELS);
         end
         FUNC_COMPUTE: begin
            op   = OP_COMPUTE;
            keep = (32'(req_index) < NUM_FERNS);
         end
         default: begin
            op   = OP_WR_TESTER;
            keep = 1'b0;
         end
      endcase
   end

   // The held command moves into the queue whenever the queue has room; an accepted command refills the hold stage.
   always_comb begin
      held_in = held_ff && q_full;
      if (accept && keep) begin
         held_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         cmd_ff.op    <= op;
         cmd_ff.index <= req_index;
         cmd_ff.loc_x <= req_loc_x;
         cmd_ff.loc_y <= req_loc_y;
         cmd_ff.value <= req_value;
      end
   end

endmodule

[sv/rfce_back.sv]
`timescale 1ns / 1ps

module rfce_back #(
   parameter int NUM_FERNS     = rfce_pkg::DEF_NUM_FERNS,
   parameter int NUM_DECISIONS = rfce_pkg::DEF_NUM_DECISIONS,
   parameter int MAX_PIXELS    = rfce_pkg::DEF_MAX_PIXELS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rfce_pkg::IMGW_W-1:0]  image_width,
   input  rfce_pkg::cmd_type            q_head,
   input  logic                         q_empty,
   output logic                         q_pop,
   output rfce_pkg::rsp_type            rsp
);

   import rfce_pkg::*;

   localparam int TESTER_DEPTH = NUM_FERNS * NUM_DECISIONS;
   localparam int TAW = (TESTER_DEPTH > 1) ? $clog2(TESTER_DEPTH) : 1;
   localparam int PAW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int DW  = (NUM_DECISIONS > 1) ? $clog2(NUM_DECISIONS) : 1;
   localparam int TESTER_W = 2 * LOC_W + VALUE_W;

   state_type            state_ff, state_in;
   logic [FERN_W-1:0]    fern_ff, fern_in;
   logic [DW-1:0]        dcnt_ff, dcnt_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic                 err_ff, err_in;
   logic                 last_issue;

   logic                 tester_we, pixel_we, start_compute, issue;
   logic [TAW-1:0]       tester_rd_addr;
   logic [TESTER_W-1:0]  tester_wr_data, tester_rd_data;
   logic [VALUE_W-1:0]   pixel_rd_data;

   // Pipeline stage 1: tester read in flight.
   logic                 s1_valid_ff, s1_last_ff;
   logic [DW-1:0]        s1_dec_ff;
   // Pipeline stage 2: pixel address formed.
   logic                 s2_valid_ff, s2_last_ff, s2_inrange_ff;
   logic [DW-1:0]        s2_dec_ff;
   logic [VALUE_W-1:0]   s2_limit_ff;
   logic [PAW-1:0]       s2_paddr_ff;
   // Pipeline stage 3: pixel read in flight.
   logic                 s3_valid_ff, s3_last_ff, s3_inrange_ff;
   logic [DW-1:0]        s3_dec_ff;
   logic [VALUE_W-1:0]   s3_limit_ff;

   logic [LOC_W-1:0]     t_col, t_row;
   logic [VALUE_W-1:0]   t_limit;
   logic [PADDR_W-1:0]   paddr_full;
   logic                 paddr_ok;
   logic                 decision_bit;
   logic [CODE_W-1:0]    decision_vec;
   rsp_type              rsp_ff, rsp_in;

   assign last_issue = (dcnt_ff == DW'(NUM_DECISIONS - 1));

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && (q_head.op == OP_COMPUTE)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s3_valid_ff && s3_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      q_pop         = 1'b0;
      tester_we     = 1'b0;
      pixel_we      = 1'b0;
      start_compute = 1'b0;
      issue         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop         = !q_empty;
            tester_we     = !q_empty && (q_head.op == OP_WR_TESTER);
            pixel_we      = !q_empty && (q_head.op == OP_WR_PIXEL);
            start_compute = !q_empty && (q_head.op == OP_COMPUTE);
         end
         ST_ISSUE: begin
            issue = 1'b1;
         end
         ST_DRAIN: begin
            issue = 1'b0;
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   // Fern number and decision counter.
   always_comb begin
      fern_in = fern_ff;
      dcnt_in = dcnt_ff;
      if (start_compute) begin
         fern_in = q_head.index[FERN_W-1:0];
         dcnt_in = '0;
      end else if (issue && !last_issue) begin
         dcnt_in = dcnt_ff + 1'b1;
      end
   end

   assign tester_rd_addr = TAW'(32'(fern_ff) * NUM_DECISIONS + 32'(dcnt_ff));
   assign tester_wr_data = {q_head.value, q_head.loc_y, q_head.loc_x};

   rfce_ram #(
      .WIDTH (TESTER_W),
      .DEPTH (TESTER_DEPTH)
   ) u_tester_ram (
      .clock   (clock),
      .wr_en   (tester_we),
      .wr_addr (q_head.index[TAW-1:0]),
      .wr_data (tester_wr_data),
      .rd_en   (issue),
      .rd_addr (tester_rd_addr),
      .rd_data (tester_rd_data)
   );

   // Pixel address is row * width + column, checked against the store size.
   assign t_col      = tester_rd_data[LOC_W-1:0];
   assign t_row      = tester_rd_data[2*LOC_W-1:LOC_W];
   assign t_limit    = tester_rd_data[TESTER_W-1:2*LOC_W];
   assign paddr_full = PADDR_W'(t_row) * PADDR_W'(image_width) + PADDR_W'(t_col);
   assign paddr_ok   = (paddr_full < PADDR_W'(MAX_PIXELS));

   rfce_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_PIXELS)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pixel_we),
      .wr_addr (q_head.index[PAW-1:0]),
      .wr_data (q_head.value),
      .rd_en   (s2_valid_ff && s2_inrange_ff),
      .rd_addr (s2_paddr_ff),
      .rd_data (pixel_rd_data)
   );

   // Signed Q16.16 comparison of the sample against the threshold.
   assign decision_bit = s3_inrange_ff &&
                         ($signed(pixel_rd_data) >= $signed(s3_limit_ff));
   assign decision_vec = CODE_W'(decision_bit) << s3_dec_ff;

   // Code and error accumulation over the fern's decisions.
   always_comb begin
      code_in = code_ff;
      err_in  = err_ff;
      if (start_compute) begin
         code_in = '0;
         err_in  = 1'b0;
      end else if (s3_valid_ff) begin
         code_in = code_ff | decision_vec;
         err_in  = err_ff | !s3_inrange_ff;
      end
   end

   // Result register, loaded in the cycle after the last decision resolves.
   always_comb begin
      rsp_in.strobe      = s3_valid_ff && s3_last_ff;
      rsp_in.fern_number = fern_ff;
      rsp_in.code        = code_ff | decision_vec;
      rsp_in.addr_error  = err_ff | !s3_inrange_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         rsp_ff      <= rsp_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      fern_ff       <= fern_in;
      dcnt_ff       <= dcnt_in;
      code_ff       <= code_in;
      err_ff        <= err_in;
      s1_last_ff    <= last_issue;
      s1_dec_ff     <= dcnt_ff;
      s2_last_ff    <= s1_last_ff;
      s2_dec_ff     <= s1_dec_ff;
      s2_limit_ff   <= t_limit;
      s2_inrange_ff <= paddr_ok;
      s2_paddr_ff   <= paddr_full[PAW-1:0];
      s3_last_ff    <= s2_last_ff;
      s3_dec_ff     <= s2_dec_ff;
      s3_limit_ff   <= s2_limit_ff;
      s3_inrange_ff <= s2_inrange_ff;
   end

   assign rsp = rsp_ff;

endmodule

[sv/rfce_checker.sv]
`timescale 1ns / 1ps

module rfce_checker #(
   parameter int NUM_FERNS     = rfce_pkg::DEF_NUM_FERNS,
   parameter int NUM_DECISIONS = rfce_pkg::DEF_NUM_DECISIONS
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_strobe,
   input logic [rfce_pkg::FERN_W-1:0]  rsp_fern_number,
   input logic [rfce_pkg::CODE_W-1:0]  rsp_code
);

   import rfce_pkg::*;

   // No result transaction in the first cycle after reset is released.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   // Result strobes never come in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobes in consecutive cycles");

   // Code bits beyond the decision count stay clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((32'(rsp_code) >> NUM_DECISIONS) == 0))
      else $error("code bit set beyond decision count");

   // Only ferns that exist are reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_fern_number) < NUM_FERNS))
      else $error("result for fern out of range");

endmodule

bind random_fern_code_encoder rfce_checker #(
   .NUM_FERNS     (NUM_FERNS),
   .NUM_DECISIONS (NUM_DECISIONS)
) u_rfce_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_strobe      (rsp_strobe),
   .rsp_fern_number (rsp_fern_number),
   .rsp_code        (rsp_code)
);

[dv/random_fern_code_encoder_tb.sv]
`timescale 1ns / 1ps

module random_fern_code_encoder_tb;
   import rfce_pkg::*;

   localparam int NF            = DEF_NUM_FERNS;
   localparam int ND            = DEF_NUM_DECISIONS;
   localparam int NPIX          = DEF_MAX_PIXELS;
   localparam int TESTERS       = NF * ND;
   localparam int PHASE_ITEMS   = 190;
   localparam int NUM_PHASES    = 6;
   localparam int SETTLE_CYCLES = 2 * (ND + 5) + 8;
   localparam int STALL_LIMIT   = 2000;

   // Selector value that the block does not decode.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] index;
      logic [LOC_W-1:0]   loc_x;
      logic [LOC_W-1:0]   loc_y;
      logic [VALUE_W-1:0] value;
   } fern_cmd_type;

   typedef struct packed {
      logic [FERN_W-1:0] fern;
      logic [CODE_W-1:0] code;
      logic              addr_error;
   } fern_code_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [INDEX_W-1:0]  req_index = '0;
   logic [LOC_W-1:0]    req_loc_x = '0;
   logic [LOC_W-1:0]    req_loc_y = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                rsp_strobe;
   logic [FERN_W-1:0]   rsp_fern_number;
   logic [CODE_W-1:0]   rsp_code;
   logic                rsp_addr_error;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [IMGW_W-1:0]   csr_image_width = '0;

   // Commands waiting for the driver, and fern codes waiting for the block.
   fern_cmd_type  fern_cmd_q [$];
   fern_code_type code_expect_q [$];
   int            fern_pool [$];

   // Predicted block state, updated as transactions are accepted.
   logic [LOC_W-1:0]   shadow_col   [TESTERS];
   logic [LOC_W-1:0]   shadow_row   [TESTERS];
   logic [VALUE_W-1:0] shadow_limit [TESTERS];
   logic [VALUE_W-1:0] shadow_pixel [NPIX];
   logic [IMGW_W-1:0]  shadow_width = IMGW_RESET;

   // Stimulus-side view of the stores, used so that no unwritten entry is read.
   logic [LOC_W-1:0]   plan_col   [TESTERS];
   logic [LOC_W-1:0]   plan_row   [TESTERS];
   logic [VALUE_W-1:0] plan_limit [TESTERS];
   bit                 plan_tester_set [TESTERS];
   bit                 plan_pixel_set  [NPIX];
   logic [IMGW_W-1:0]  plan_width = IMGW_RESET;
   int                 plan_effective = 0;

   int cmds_issued      = 0;
   int cmds_accepted    = 0;
   int cmds_dropped     = 0;
   int csr_writes       = 0;
   int codes_checked    = 0;
   int codes_with_error = 0;
   int mismatch_count   = 0;
   int quiet_cycles     = 0;
   int burst_left       = 0;
   int idle_left        = 0;

   random_fern_code_encoder #(
      .NUM_FERNS     (NF),
      .NUM_DECISIONS (ND),
      .MAX_PIXELS    (NPIX)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_index       (req_index),
      .req_loc_x       (req_loc_x),
      .req_loc_y       (req_loc_y),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_fern_number (rsp_fern_number),
      .rsp_code        (rsp_code),
      .rsp_addr_error  (rsp_addr_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_image_width (csr_image_width)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Code of one fern from the predicted stores: bit d is set when the pixel
   // under tester d is not below its threshold, signed Q16.16.
   function automatic fern_code_type predict_fern_code(input int fern);
      fern_code_type r;
      int unsigned   t;
      int unsigned   addr;
      int            d;
      r.fern       = fern[FERN_W-1:0];
      r.code       = '0;
      r.addr_error = 1'b0;
      for (d = 0; d < ND; d++) begin
         t    = fern * ND + d;
         addr = int'(shadow_row[t]) * int'(shadow_width) + int'(shadow_col[t]);
         if (addr >= NPIX)
            r.addr_error = 1'b1;
         else if ($signed(shadow_pixel[addr]) >= $signed(shadow_limit[t]))
            r.code[d] = 1'b1;
      end
      return r;
   endfunction

   // Apply one accepted transaction to the predicted state.
   function automatic void apply_fern_cmd(input fern_cmd_type c);
      case (c.func)
         FUNC_WR_TESTER: begin
            if (c.index < TESTERS) begin
               shadow_col[c.index]   = c.loc_x;
               shadow_row[c.index]   = c.loc_y;
               shadow_limit[c.index] = c.value;
            end else
               cmds_dropped++;
         end
         FUNC_WR_PIXEL: begin
            if (c.index < NPIX)
               shadow_pixel[c.index] = c.value;
            else
               cmds_dropped++;
         end
         FUNC_COMPUTE: begin
            if (c.index < NF)
               code_expect_q.push_back(predict_fern_code(c.index));
            else
               cmds_dropped++;
         end
         default: cmds_dropped++;
      endcase
   endfunction

   // Queue a command and track what it leaves written.
   function automatic void queue_cmd(input logic [FUNC_W-1:0] func, input int index,
                                     input int lx, input int ly, input logic [31:0] value);
      fern_cmd_type c;
      c.func  = func;
      c.index = index[INDEX_W-1:0];
      c.loc_x = lx[LOC_W-1:0];
      c.loc_y = ly[LOC_W-1:0];
      c.value = value;
      fern_cmd_q.push_back(c);
      case (func)
         FUNC_WR_TESTER: begin
            if (index < TESTERS) begin
               plan_col[index]        = c.loc_x;
               plan_row[index]        = c.loc_y;
               plan_limit[index]      = value;
               plan_tester_set[index] = 1'b1;
               plan_effective++;
            end
         end
         FUNC_WR_PIXEL: begin
            if (index < NPIX) begin
               plan_pixel_set[index] = 1'b1;
               plan_effective++;
            end
         end
         FUNC_COMPUTE: if (index < NF) plan_effective++;
         default: ;
      endcase
   endfunction

   function automatic int plan_addr(input int t);
      return int'(plan_row[t]) * int'(plan_width) + int'(plan_col[t]);
   endfunction

   // A fern may be computed only when every tester and every in-range pixel
   // it touches has been written.
   function automatic bit fern_ready(input int fern);
      int d;
      int t;
      for (d = 0; d < ND; d++) begin
         t = fern * ND + d;
         if (!plan_tester_set[t])
            return 1'b0;
         if (plan_addr(t) < NPIX && !plan_pixel_set[plan_addr(t)])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
         default: return $urandom();
      endcase
   endfunction

   // Samples sit on, just above or just below the threshold most of the time.
   function automatic logic [31:0] pick_sample(input logic [31:0] limit);
      case ($urandom_range(0, 4))
         0: return limit;
         1: return limit + 32'd1;
         2: return limit - 32'd1;
         3: return pick_q16();
         default: return $urandom();
      endcase
   endfunction

   // Write all testers of a fern, mostly inside the image, then the pixels
   // they point at.
   function automatic void prepare_fern(input int fern);
      int d;
      int t;
      int col;
      int row;
      int max_row;
      for (d = 0; d < ND; d++) begin
         t   = fern * ND + d;
         col = $urandom_range(0, 255);
         if (plan_width == 0 || $urandom_range(0, 99) < 15)
            row = $urandom_range(0, 255);
         else begin
            max_row = (NPIX - 1 - col) / int'(plan_width);
            if (max_row > 255)
               max_row = 255;
            row = $urandom_range(0, max_row);
         end
         queue_cmd(FUNC_WR_TESTER, t, col, row, pick_q16());
      end
      for (d = 0; d < ND; d++) begin
         t = fern * ND + d;
         if (plan_addr(t) < NPIX)
            queue_cmd(FUNC_WR_PIXEL, plan_addr(t), $urandom_range(0, 255),
                      $urandom_range(0, 255), pick_sample(plan_limit[t]));
      end
   endfunction

   // Items the block must drop: unused selector, tester index past the
   // table, fern number past the last fern.
   function automatic void queue_noise();
      case ($urandom_range(0, 2))
         0: queue_cmd(FUNC_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom());
         1: queue_cmd(FUNC_WR_TESTER, $urandom_range(TESTERS, 8191), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom());
         default: queue_cmd(FUNC_COMPUTE, $urandom_range(NF, 8191), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom());
      endcase
   endfunction

   function automatic void queue_directed();
      // Fern 0: threshold extremes, the last pixel, and one tester off the image.
      queue_cmd(FUNC_WR_TESTER, 0, 0, 0, 32'h8000_0000);
      queue_cmd(FUNC_WR_TESTER, 1, 255, 0, 32'h7FFF_FFFF);
      queue_cmd(FUNC_WR_TESTER, 2, 31, 102, 32'h0000_0000);
      queue_cmd(FUNC_WR_TESTER, 3, 255, 255, 32'hFFFF_FFFF);
      queue_cmd(FUNC_WR_PIXEL, 0, 255, 255, 32'h8000_0000);
      queue_cmd(FUNC_WR_PIXEL, 255, 0, 0, 32'h7FFF_FFFE);
      queue_cmd(FUNC_WR_PIXEL, NPIX - 1, 255, 255, 32'h0000_0000);
      queue_cmd(FUNC_COMPUTE, 0, 0, 0, 32'h0000_0000);
      // Last fern: thresholds one step either side of or equal to the stored samples, one far above its sample.
      queue_cmd(FUNC_WR_TESTER, TESTERS - 4, 0, 0, 32'h8000_0001);
      queue_cmd(FUNC_WR_TESTER, TESTERS - 3, 255, 0, 32'h7FFF_FFFF);
      queue_cmd(FUNC_WR_TESTER, TESTERS - 2, 31, 102, 32'hFFFF_FFFF);
      queue_cmd(FUNC_WR_TESTER, TESTERS - 1, 0, 0, 32'h7FFF_FFFF);
      queue_cmd(FUNC_WR_PIXEL, 255, 0, 0, 32'h7FFF_FFFF);
      queue_cmd(FUNC_COMPUTE, NF - 1, 255, 255, 32'hFFFF_FFFF);
      // Dropped items, then fern 0 again to show they changed nothing.
      queue_cmd(FUNC_WR_TESTER, TESTERS, 255, 255, 32'h0000_0000);
      queue_cmd(FUNC_WR_TESTER, 8191, 255, 255, 32'hFFFF_FFFF);
      queue_cmd(FUNC_COMPUTE, NF, 0, 0, 32'h0000_0000);
      queue_cmd(FUNC_COMPUTE, 8191, 255, 255, 32'hFFFF_FFFF);
      queue_cmd(FUNC_UNUSED, 8191, 255, 255, 32'hFFFF_FFFF);
      queue_cmd(FUNC_UNUSED, 0, 0, 0, 32'h0000_0000);
      queue_cmd(FUNC_COMPUTE, 0, 255, 255, 32'hFFFF_FFFF);
      fern_pool.push_back(0);
      fern_pool.push_back(NF - 1);
   endfunction

   // Mostly well-formed fern setups followed by a compute, with recomputes,
   // pixel rewrites and dropped items mixed in.
   function automatic void queue_random_phase();
      int goal;
      int pick;
      int fern;
      int t;
      goal = plan_effective + PHASE_ITEMS;
      while (plan_effective < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 40 || fern_pool.size() == 0) begin
            if ($urandom_range(0, 9) == 0)
               fern = ($urandom_range(0, 1) != 0) ? NF - 1 : 0;
            else
               fern = $urandom_range(0, NF - 1);
            prepare_fern(fern);
            queue_cmd(FUNC_COMPUTE, fern, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom());
            fern_pool.push_back(fern);
         end else if (pick < 75) begin
            fern = fern_pool[$urandom_range(0, fern_pool.size() - 1)];
            if (!fern_ready(fern))
               prepare_fern(fern);
            queue_cmd(FUNC_COMPUTE, fern, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom());
         end else if (pick < 88) begin
            fern = fern_pool[$urandom_range(0, fern_pool.size() - 1)];
            t    = fern * ND + $urandom_range(0, ND - 1);
            if (plan_tester_set[t] && plan_addr(t) < NPIX)
               queue_cmd(FUNC_WR_PIXEL, plan_addr(t), $urandom_range(0, 255),
                         $urandom_range(0, 255), pick_sample(plan_limit[t]));
            else
               queue_cmd(FUNC_WR_PIXEL, $urandom_range(0, NPIX - 1), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom());
         end else
            queue_noise();
      end
   endfunction

   // Wait until every command is taken and every code is back, then let
   // trailing writes finish inside the block.
   task automatic wait_for_drain();
      while (fern_cmd_q.size() != 0 || code_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_image_width(input logic [IMGW_W-1:0] w);
      int target;
      target     = csr_writes + 1;
      plan_width = w;
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_image_width <= w;
      while (csr_writes < target)
         @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Driver: presents queued commands in bursts separated by random gaps.
   always @(negedge clock) begin : driver
      fern_cmd_type c;
      if (reset)
         start <= 1'b0;
      else if (start && cmds_accepted < cmds_issued) begin
         // Current transaction not yet taken; hold it.
      end else begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         end
         if (idle_left > 0) begin
            start <= 1'b0;
            idle_left--;
         end else if (fern_cmd_q.size() != 0) begin
            c = fern_cmd_q[0];
            start     <= 1'b1;
            req_func  <= c.func;
            req_index <= c.index;
            req_loc_x <= c.loc_x;
            req_loc_y <= c.loc_y;
            req_value <= c.value;
            cmds_issued++;
            burst_left--;
         end else
            start <= 1'b0;
      end
   end

   // Monitor: tracks accepted transactions, checks results and watches for
   // a stalled block.
   always @(posedge clock) begin : monitor
      fern_cmd_type  c;
      fern_code_type e;
      bit            moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            shadow_width = csr_image_width;
            csr_writes++;
            moved = 1'b1;
         end
         if (rsp_strobe) begin
            moved = 1'b1;
            if (code_expect_q.size() == 0)
               report_mismatch($sformatf("code for fern %0d with none expected",
                                         rsp_fern_number));
            else begin
               e = code_expect_q.pop_front();
               codes_checked++;
               if (e.addr_error)
                  codes_with_error++;
               if (rsp_fern_number !== e.fern)
                  report_mismatch($sformatf("fern_number %0d, expected %0d",
                                            rsp_fern_number, e.fern));
               if (rsp_code !== e.code)
                  report_mismatch($sformatf("fern %0d code %02h, expected %02h",
                                            e.fern, rsp_code, e.code));
               if (rsp_addr_error !== e.addr_error)
                  report_mismatch($sformatf("fern %0d addr_error %b, expected %b",
                                            e.fern, rsp_addr_error, e.addr_error));
            end
         end
         if (start && !busy) begin
            c = fern_cmd_q.pop_front();
            cmds_accepted++;
            apply_fern_cmd(c);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d codes outstanding",
                     STALL_LIMIT, code_expect_q.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Stimulus: directed items at the reset width, then random phases at
   // widths that include both ends of the register.
   initial begin : stimulus
      logic [IMGW_W-1:0] widths [NUM_PHASES];
      int                phase;
      widths = '{IMGW_RESET, 9'd1, 9'd256, 9'd0, 9'd511, 9'd0};
      widths[NUM_PHASES - 1] = $urandom_range(2, 255);
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      queue_directed();
      queue_random_phase();
      for (phase = 1; phase < NUM_PHASES; phase++) begin
         wait_for_drain();
         write_image_width(widths[phase]);
         @(posedge clock);
         queue_random_phase();
      end
      wait_for_drain();
      $display("Covered %0d transactions (%0d dropped by the block) over %0d image widths.",
               cmds_accepted, cmds_dropped, csr_writes + 1);
      $display("Checked %0d fern codes, %0d of them with the address error flag.",
               codes_checked, codes_with_error);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
sv/rfce_pkg.sv
sv/rfce_ram.sv
sv/rfce_queue.sv
sv/rfce_front.sv
sv/rfce_back.sv
sv/random_fern_code_encoder.sv
sv/rfce_checker.sv
dv/random_fern_code_encoder_tb.sv
